// ===== src/cpuop_pkg.sv =====
// ============================================================================
// cpuop_pkg - shared types and constants of the operating point selector
// Multiplier ROMs, control word fields, bus speeds, register indexes and the
// structures passed between the selector's modules.
// ============================================================================
package cpuop_pkg;

   // Number of multiplier entries searched by default.
   localparam int DEF_RATIO_ENTRIES = 32;
   localparam int ROM_DEPTH         = 32;

   // Beat layouts.
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 64;

   // Configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 12;

   localparam logic [CSR_INDEX_W-1:0] CSR_VERSION  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BUS_SCL  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FAST_BUS = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIX_BUS  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOWEST   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_HIGHEST  = 3'd5;

   // ROM versions (the unused fourth code behaves as the third version).
   localparam logic [1:0] VER_FIRST  = 2'd0;
   localparam logic [1:0] VER_SECOND = 2'd1;
   localparam logic [1:0] VER_THIRD  = 2'd2;
   localparam logic [1:0] VER_SPARE  = 2'd3;

   // Bus speeds in MHz and their encodings.
   localparam logic [7:0] BUS_66  = 8'd66;
   localparam logic [7:0] BUS_100 = 8'd100;
   localparam logic [7:0] BUS_133 = 8'd133;

   localparam logic [1:0] BUS_CODE_133   = 2'd0;
   localparam logic [1:0] BUS_CODE_100   = 2'd1;
   localparam logic [1:0] BUS_CODE_OTHER = 2'd2;
   localparam logic [1:0] BUS_CODE_66    = 2'd3;

   // Control word fields.
   localparam logic [31:0] CTL_KEEP_MASK  = 32'hfff0_bf0f;
   localparam logic [31:0] CTL_V0_RATIO   = 32'h0780_0000;
   localparam logic [31:0] CTL_V0_ENABLE  = 32'h0008_0000;
   localparam logic [31:0] CTL_ENABLE     = 32'h0000_0100;
   localparam logic [31:0] CTL_BUS_FIELD  = 32'h3000_0000;

   // Multiplier ROMs, ten times the ratio; zero marks a reserved entry.
   localparam logic [7:0] ROM_V0 [ROM_DEPTH] = '{
      8'd0,  8'd30, 8'd40, 8'd0,  8'd0,  8'd35, 8'd45, 8'd55,
      8'd60, 8'd70, 8'd80, 8'd50, 8'd65, 8'd75, 8'd0,  8'd0,
      8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,
      8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0
   };
   localparam logic [7:0] ROM_V1 [ROM_DEPTH] = '{
      8'd100, 8'd30, 8'd40, 8'd90, 8'd95, 8'd35, 8'd45, 8'd55,
      8'd60,  8'd70, 8'd80, 8'd50, 8'd65, 8'd75, 8'd85, 8'd120,
      8'd0,   8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,
      8'd0,   8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0
   };
   localparam logic [7:0] ROM_V2 [ROM_DEPTH] = '{
      8'd100, 8'd30,  8'd40,  8'd90,  8'd95,  8'd35,  8'd45,  8'd55,
      8'd60,  8'd70,  8'd80,  8'd50,  8'd65,  8'd75,  8'd85,  8'd120,
      8'd0,   8'd110, 8'd120, 8'd0,   8'd105, 8'd115, 8'd125, 8'd135,
      8'd140, 8'd150, 8'd160, 8'd130, 8'd145, 8'd155, 8'd0,   8'd0
   };

   // Configuration register set.
   typedef struct packed {
      logic [1:0]  version;
      logic        bus_scaling;
      logic        fast_bus;
      logic [7:0]  fixed_bus;
      logic [11:0] lowest;
      logic [11:0] highest;
   } cfg_type;

   // What every multiplier lane needs to evaluate its candidates.
   typedef struct packed {
      logic [1:0]       version;
      logic [2:0][7:0]  bus;
      logic [2:0]       bus_en;
      logic [12:0]      limit;
      logic [11:0]      lowest;
      logic [11:0]      highest;
   } lane_in_type;

   // One candidate operating point.
   typedef struct packed {
      logic        hit;
      logic [11:0] clock;
      logic [4:0]  code;
      logic [7:0]  bus;
   } node_type;

   // Fractional part of the clock: bus divided by a small constant divisor.
   // The divisors by three, five and ten use reciprocals exact for 8-bit buses.
   function automatic logic [7:0] bus_part(input logic [7:0] bus, input logic [3:0] div);
      logic [15:0] prod;
      logic [7:0]  res;
      prod = 16'd0;
      res  = 8'd0;
      case (div)
         4'd1: res = bus;
         4'd2: res = bus >> 1;
         4'd3: begin
            prod = {8'd0, bus} * 16'd171;
            res  = 8'(prod >> 9);
         end
         4'd5: begin
            prod = {8'd0, bus} * 16'd205;
            res  = 8'(prod >> 10);
         end
         4'd10: begin
            prod = {8'd0, bus} * 16'd205;
            res  = 8'(prod >> 11);
         end
         default: res = 8'd0;
      endcase
      return res;
   endfunction

endpackage

// ===== src/cpu_clock_operating_point_select_unit.sv =====
// ============================================================================
// cpu_clock_operating_point_select_unit - core clock operating point selector
// Chooses the best multiplier and bus speed for a requested core clock and
// rebuilds the clock-control word to match.
// ============================================================================
// A request beat carries the wanted core clock in MHz and the present
// clock-control word. The request is clamped to the configured range, and
// every multiplier of the selected ROM is tried against the fixed bus speed,
// or against 66, 100 and 133 MHz when bus scaling is on. The highest clock
// inside the range and no more than one above the request wins; ties go to
// the lower ratio code and then to the first bus in search order. The block
// answers with that clock, ratio code, bus speed and bus code, the rebuilt
// control word, and a found flag in rsp_tuser; with nothing found the clock
// fields are zero and the control word comes back unchanged. Each request
// gives exactly one response beat, offered from the response register after
// passing the request register, and a new request is taken every cycle while
// the response side is not stalled: the request register feeds one lane per
// multiplier entry, a compare tree over the lanes and the control word
// rebuild, all combinational into the response register, so the depth of that
// lane-plus-tree path sets the clock period.
// Configuration writes are taken at any time (csr_ready is always high) but
// must only be made while no request is in flight.
// ============================================================================
module cpu_clock_operating_point_select_unit
   import cpuop_pkg::*;
#(
   parameter int MAX_RATIO_ENTRIES = DEF_RATIO_ENTRIES
) (
   input  logic                   clock,
   input  logic                   reset,
   // Request beats
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // requested_mhz[11:0], current_control[43:12]
   // Response beats
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // chosen_mhz[11:0], ratio_code[16:12],
                                               // bus_mhz[24:17], bus_code[26:25],
                                               // new_control[58:27]
   output logic                   rsp_tuser,   // found
   // Configuration writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type     cfg;
   logic [1:0]  version;

   // Request stage
   logic        s1_valid_ff, s1_valid_in;
   logic [11:0] s1_freq_ff;
   logic [31:0] s1_ctl_ff;
   logic        req_take;
   logic        s1_move;

   // Response stage
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_found_ff;

   // Selection path
   logic [11:0] freq_lo;
   logic [11:0] freq;
   lane_in_type lane_in;
   node_type    leaf [MAX_RATIO_ENTRIES];
   node_type    best;
   logic [11:0] chosen;
   logic [4:0]  code;
   logic [7:0]  bus;
   logic [31:0] new_ctl;
   logic [1:0]  bus_code;

   assign csr_ready = 1'b1;

   cpuop_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg_o    (cfg)
   );

   // The spare version code behaves as the third version.
   assign version = (cfg.version == VER_SPARE) ? VER_THIRD : cfg.version;

   // ---------------------------------------------------------------------
   // Handshake: the request register moves on whenever the response
   // register is empty or its beat is being taken.
   // ---------------------------------------------------------------------
   assign s1_move    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_move;
   assign req_take   = req_tvalid && req_tready;

   assign s1_valid_in  = req_take ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_move ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_freq_ff <= req_tdata[11:0];
         s1_ctl_ff  <= req_tdata[43:12];
      end
      if (s1_move) begin
         rsp_data_ff  <= rsp_data_in;
         rsp_found_ff <= best.hit;
      end
   end

   // ---------------------------------------------------------------------
   // Clamp the request; raising to the lower bound comes first, so an
   // inverted range ends at the upper bound and nothing can qualify.
   // ---------------------------------------------------------------------
   assign freq_lo = (s1_freq_ff < cfg.lowest) ? cfg.lowest : s1_freq_ff;
   assign freq    = (freq_lo > cfg.highest) ? cfg.highest : freq_lo;

   always_comb begin
      lane_in.version = version;
      lane_in.limit   = {1'b0, freq} + 13'd1;
      lane_in.lowest  = cfg.lowest;
      lane_in.highest = cfg.highest;
      if (!cfg.bus_scaling) begin
         lane_in.bus    = {8'd0, 8'd0, cfg.fixed_bus};
         lane_in.bus_en = 3'b001;
      end else if (cfg.fast_bus) begin
         lane_in.bus    = {BUS_66, BUS_100, BUS_133};
         lane_in.bus_en = 3'b111;
      end else begin
         lane_in.bus    = {BUS_133, BUS_100, BUS_66};
         lane_in.bus_en = 3'b111;
      end
   end

   // One lane per multiplier entry.
   for (genvar i = 0; i < MAX_RATIO_ENTRIES; i++) begin : g_lane
      cpuop_lane #(
         .IDX (i)
      ) u_lane (
         .lane_i (lane_in),
         .node_o (leaf[i])
      );
   end

   cpuop_tree #(
      .ENTRIES (MAX_RATIO_ENTRIES)
   ) u_tree (
      .leaf_i (leaf),
      .best_o (best)
   );

   // Fields read as zero when nothing qualifies.
   assign chosen = best.hit ? best.clock : 12'd0;
   assign code   = best.hit ? best.code  : 5'd0;
   assign bus    = best.hit ? best.bus   : 8'd0;

   cpuop_word u_word (
      .ctl_i         (s1_ctl_ff),
      .hit_i         (best.hit),
      .code_i        (code),
      .bus_i         (bus),
      .version_i     (version),
      .bus_scaling_i (cfg.bus_scaling),
      .ctl_o         (new_ctl),
      .bus_code_o    (bus_code)
   );

   assign rsp_data_in = {5'd0, new_ctl, bus_code, bus, code, chosen};

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_found_ff;

endmodule

// ===== src/cpuop_csr.sv =====
// ============================================================================
// cpuop_csr - configuration registers
// Holds the six selector settings, written through the index/data port.
// ============================================================================
module cpuop_csr
   import cpuop_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  logic [CSR_INDEX_W-1:0] wr_index,
   input  logic [CSR_DATA_W-1:0]  wr_data,
   output cfg_type                cfg_o
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            CSR_VERSION:  cfg_in.version     = wr_data[1:0];
            CSR_BUS_SCL:  cfg_in.bus_scaling = wr_data[0];
            CSR_FAST_BUS: cfg_in.fast_bus    = wr_data[0];
            CSR_FIX_BUS:  cfg_in.fixed_bus   = wr_data[7:0];
            CSR_LOWEST:   cfg_in.lowest      = wr_data[11:0];
            CSR_HIGHEST:  cfg_in.highest     = wr_data[11:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.version     <= VER_SECOND;
         cfg_ff.bus_scaling <= 1'b0;
         cfg_ff.fast_bus    <= 1'b0;
         cfg_ff.fixed_bus   <= BUS_100;
         cfg_ff.lowest      <= 12'd0;
         cfg_ff.highest     <= 12'd4095;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg_o = cfg_ff;

endmodule

// ===== src/cpuop_lane.sv =====
// ============================================================================
// cpuop_lane - one multiplier entry against the candidate bus speeds
// Works out the clock for each bus, keeps those inside the limits and gives
// the highest, the earliest bus in search order winning a tie.
// ============================================================================
module cpuop_lane
   import cpuop_pkg::*;
#(
   parameter int IDX = 0
) (
   input  lane_in_type lane_i,
   output node_type    node_o
);

   // Whole and fractional parts of this entry, per ROM version.
   localparam int R0 = int'(ROM_V0[IDX]);
   localparam int R1 = int'(ROM_V1[IDX]);
   localparam int R2 = int'(ROM_V2[IDX]);
   localparam int W0 = R0 / 10;
   localparam int W1 = R1 / 10;
   localparam int W2 = R2 / 10;
   localparam int D0 = (R0 % 10 == 0) ? 0 : 10 / (R0 % 10);
   localparam int D1 = (R1 % 10 == 0) ? 0 : 10 / (R1 % 10);
   localparam int D2 = (R2 % 10 == 0) ? 0 : 10 / (R2 % 10);

   logic [4:0]  whole;
   logic [3:0]  div;
   logic [12:0] clk [3];
   node_type    best;

   always_comb begin
      case (lane_i.version)
         VER_FIRST: begin
            whole = 5'(W0);
            div   = 4'(D0);
         end
         VER_SECOND: begin
            whole = 5'(W1);
            div   = 4'(D1);
         end
         default: begin
            whole = 5'(W2);
            div   = 4'(D2);
         end
      endcase
   end

   always_comb begin
      best      = '0;
      best.code = 5'(IDX);
      for (int k = 0; k < 3; k++) begin
         clk[k] = 13'(13'(whole) * 13'(lane_i.bus[k])) + 13'(bus_part(lane_i.bus[k], div));
         if (lane_i.bus_en[k] && clk[k] != 13'd0 && clk[k] <= lane_i.limit &&
             clk[k] >= {1'b0, lane_i.lowest} && clk[k] <= {1'b0, lane_i.highest} &&
             (!best.hit || clk[k][11:0] > best.clock)) begin
            best.hit   = 1'b1;
            best.clock = clk[k][11:0];
            best.bus   = lane_i.bus[k];
         end
      end
   end

   assign node_o = best;

endmodule

// ===== src/cpuop_tree.sv =====
// ============================================================================
// cpuop_tree - highest-clock selection across the multiplier lanes
// A binary compare tree; on equal clocks the lower ratio code wins.
// ============================================================================
module cpuop_tree
   import cpuop_pkg::*;
#(
   parameter int ENTRIES = DEF_RATIO_ENTRIES
) (
   input  node_type leaf_i [ENTRIES],
   output node_type best_o
);

   localparam int LEAVES = 1 << $clog2(ENTRIES);

   node_type node [1:2*LEAVES-1];

   for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
      if (j < ENTRIES) begin : g_used
         assign node[LEAVES+j] = leaf_i[j];
      end else begin : g_pad
         assign node[LEAVES+j] = '0;
      end
   end

   for (genvar j = 1; j < LEAVES; j++) begin : g_node
      // The left child holds the lower codes, so it keeps a tie.
      assign node[j] = (node[2*j+1].hit &&
                        (!node[2*j].hit || node[2*j+1].clock > node[2*j].clock))
                       ? node[2*j+1] : node[2*j];
   end

   assign best_o = node[1];

endmodule

// ===== src/cpuop_word.sv =====
// ============================================================================
// cpuop_word - control word rebuild
// Inserts ratio, enable bit, rev key and, for the third version with bus
// scaling, bus code in the ROM version's layout; encodes the chosen bus speed.
// ============================================================================
module cpuop_word
   import cpuop_pkg::*;
(
   input  logic [31:0] ctl_i,
   input  logic        hit_i,
   input  logic [4:0]  code_i,
   input  logic [7:0]  bus_i,
   input  logic [1:0]  version_i,
   input  logic        bus_scaling_i,
   output logic [31:0] ctl_o,
   output logic [1:0]  bus_code_o
);

   logic [31:0] key;
   logic [1:0]  bcode;

   always_comb begin
      if (bus_i == BUS_133)      bcode = BUS_CODE_133;
      else if (bus_i == BUS_100) bcode = BUS_CODE_100;
      else if (bus_i == BUS_66)  bcode = BUS_CODE_66;
      else                       bcode = BUS_CODE_OTHER;
   end

   always_comb begin
      key        = {24'd0, ctl_i[3:0], 4'd0};
      ctl_o      = ctl_i;
      bus_code_o = 2'd0;
      if (hit_i) begin
         bus_code_o = bcode;
         if (version_i == VER_FIRST) begin
            // First layout: the old rev key bits are not cleared first.
            ctl_o = (ctl_i & ~CTL_V0_RATIO) | CTL_V0_ENABLE |
                    {5'd0, code_i[3:0], 23'd0} | key;
         end else begin
            ctl_o = (ctl_i & CTL_KEEP_MASK) | {12'd0, code_i[3:0], 16'd0} |
                    {17'd0, code_i[4], 14'd0} | CTL_ENABLE | key;
            if (version_i == VER_THIRD && bus_scaling_i) begin
               ctl_o = (ctl_o & ~CTL_BUS_FIELD) | {2'd0, bcode, 28'd0};
            end
         end
      end
   end

endmodule

// ===== src/cpuop_checker.sv =====
// ============================================================================
// cpuop_checker - port-level checks of the operating point selector
// Watches the response port for stalls, reset behaviour and consistency of
// the result fields.
// ============================================================================
module cpuop_checker
   import cpuop_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   // A stalled response beat holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response beat changed while stalled");

   // Reset empties the response register.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // With no operating point found, clock, code and bus fields are zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[26:0] == 27'd0)
      else $error("fields not cleared when nothing was found");

   // A found operating point has a non-zero clock and bus.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[11:0] != 12'd0 && rsp_tdata[24:17] != 8'd0)
      else $error("found result with zero clock or bus");

   // Bus code agrees with a found 133 MHz bus.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser && rsp_tdata[24:17] == BUS_133 |->
         rsp_tdata[26:25] == BUS_CODE_133)
      else $error("bus code does not match bus speed");

endmodule

bind cpu_clock_operating_point_select_unit cpuop_checker u_cpuop_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
